// ===== sv/wbse_pkg.sv =====
// ----------------------------------------------------------------------------
// wbse_pkg: shared types and constants
// Widths, CORDIC arctangent table and the item record passed from front to back.
// ----------------------------------------------------------------------------
package wbse_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_GUARD  = 24;
    localparam int HDG_W         = 16;
    localparam int CFG_W         = 24;

    // difference and magnitude width
    localparam int DW    = COORD_WIDTH + 1;
    // CORDIC vector width: difference scaled by guard bits plus gain headroom
    localparam int CW    = DW + CORDIC_GUARD + 3;
    // angle accumulator, degrees times 32768
    localparam int ZW    = 26;
    // squared distance and root working widths
    localparam int SQ_W  = 2 * COORD_WIDTH + 1;
    localparam int RW    = SQ_W + 1;
    localparam int SQRT_STEPS = COORD_WIDTH + 1;
    // back pipeline: squares, sum, then one root step per stage
    localparam int NS    = SQRT_STEPS + 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [HDG_W-1:0] FULL_TURN    = 16'd46080;
    localparam logic [HDG_W-1:0] HALF_TURN    = 16'd23040;
    localparam logic [HDG_W-1:0] QUARTER_TURN = 16'd11520;
    localparam logic [HDG_W-1:0] THREE_QUARTER_TURN = 16'd34560;
    localparam logic [ZW-1:0]    Z_HALF_TURN  = 26'd5898240;
    localparam logic [CFG_W-1:0] HALF_UNIT    = 24'd128;

    localparam logic [0:0] REG_SLOW_ZONE    = 1'b0;
    localparam logic [0:0] REG_CRUISE_SPEED = 1'b1;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [DW-1:0]        adx;
        logic [DW-1:0]        ady;
        logic [HDG_W-1:0]     hdg;
    } t_item;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
        logic far;
    } t_flags;

    // atan(2^-i) in degrees times 32768, rounded
    function automatic logic [ZW-1:0] atan_lut(input int i);
        logic [ZW-1:0] v;
        case (i)
            0: v = 26'd1474560;  1: v = 26'd870484;  2: v = 26'd459940;
            3: v = 26'd233473;   4: v = 26'd117189;  5: v = 26'd58652;
            6: v = 26'd29333;    7: v = 26'd14667;   8: v = 26'd7334;
            9: v = 26'd3667;    10: v = 26'd1833;   11: v = 26'd917;
            12: v = 26'd458;    13: v = 26'd229;    14: v = 26'd115;
            15: v = 26'd57;     16: v = 26'd29;     17: v = 26'd14;
            18: v = 26'd7;      19: v = 26'd4;      20: v = 26'd2;
            21: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/wbse_front.sv =====
// ----------------------------------------------------------------------------
// wbse_front: input stage
// Takes an item, forms the coordinate differences, their magnitudes and the
// reduced measured heading, and holds it until the queue takes it.
// ----------------------------------------------------------------------------
module wbse_front import wbse_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [COORD_WIDTH-1:0]   i_pos_x,
    input  logic [COORD_WIDTH-1:0]   i_pos_y,
    input  logic [COORD_WIDTH-1:0]   i_dest_x,
    input  logic [COORD_WIDTH-1:0]   i_dest_y,
    input  logic [HDG_W-1:0]         i_hdg,
    output logic                     o_valid,
    input  logic                     i_full,
    output t_item                    o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  push;
    logic  take;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    assign push    = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // differences, magnitudes, heading reduced into one turn
    always_comb begin
        dx = $signed({i_dest_x[COORD_WIDTH-1], i_dest_x})
           - $signed({i_pos_x[COORD_WIDTH-1], i_pos_x});
        dy = $signed({i_dest_y[COORD_WIDTH-1], i_dest_y})
           - $signed({i_pos_y[COORD_WIDTH-1], i_pos_y});
        n_item.dx  = dx;
        n_item.dy  = dy;
        n_item.adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        n_item.ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        n_item.hdg = (i_hdg >= FULL_TURN) ? i_hdg - FULL_TURN : i_hdg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/wbse_fifo.sv =====
// ----------------------------------------------------------------------------
// wbse_fifo: decoupling queue
// Short first-in first-out queue of items between the front and back parts.
// ----------------------------------------------------------------------------
module wbse_fifo import wbse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== sv/wbse_back.sv =====
// ----------------------------------------------------------------------------
// wbse_back: bearing and distance pipeline
// CORDIC vectoring for the bearing and a digit-by-digit square root for the
// distance, one step per stage, then speed rule, bearing wrap and heading error.
// ----------------------------------------------------------------------------
module wbse_back import wbse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_item             i_item,
    output logic              o_pop,
    input  logic [CFG_W-1:0]  i_slow_zone,
    input  logic [CFG_W-1:0]  i_cruise_speed,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [HDG_W-1:0]  o_aimed_heading,
    output logic [CFG_W-1:0]  o_speed_cmd,
    output logic [HDG_W-1:0]  o_heading_error,
    output logic              o_points_equal
);

    logic                    en;
    logic                    r_v [NS];
    logic signed [CW-1:0]    r_x [NS];
    logic signed [CW-1:0]    r_y [NS];
    logic signed [ZW-1:0]    r_z [NS];
    t_flags                  r_f [NS];
    logic [HDG_W-1:0]        r_m [NS];
    logic [SQ_W-1:0]         r_n [1:NS-1];
    logic [RW-1:0]           r_res [1:NS-1];
    logic [2*COORD_WIDTH-1:0] r_sqx;
    logic [2*COORD_WIDTH-1:0] r_sqy;

    logic                    r_fv;
    logic [HDG_W-1:0]        r_fb;
    logic [CFG_W-1:0]        r_fspd;
    logic [HDG_W-1:0]        r_fm;
    logic                    r_feq;

    logic                    r_ov;
    logic [HDG_W-1:0]        r_ob;
    logic [CFG_W-1:0]        r_ospd;
    logic [HDG_W-1:0]        r_oerr;
    logic                    r_oeq;

    logic signed [CW-1:0]    x0;
    logic signed [CW-1:0]    y0;
    t_flags                  f0;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    // stage 0: squares and CORDIC start vector, flipped into the right half plane
    always_comb begin
        x0 = {{(CW-DW-CORDIC_GUARD){i_item.dy[DW-1]}}, i_item.dy, {CORDIC_GUARD{1'b0}}};
        y0 = {{(CW-DW-CORDIC_GUARD){i_item.dx[DW-1]}}, i_item.dx, {CORDIC_GUARD{1'b0}}};
        f0.dx_zero = (i_item.dx == '0);
        f0.dy_zero = (i_item.dy == '0);
        f0.dx_neg  = i_item.dx[DW-1];
        f0.dy_neg  = i_item.dy[DW-1];
        f0.far     = i_item.adx[COORD_WIDTH] || i_item.ady[COORD_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx  <= i_item.adx[COORD_WIDTH-1:0] * i_item.adx[COORD_WIDTH-1:0];
            r_sqy  <= i_item.ady[COORD_WIDTH-1:0] * i_item.ady[COORD_WIDTH-1:0];
            r_x[0] <= f0.dy_neg ? -x0 : x0;
            r_y[0] <= f0.dy_neg ? -y0 : y0;
            r_z[0] <= f0.dy_neg ? $signed(Z_HALF_TURN) : '0;
            r_f[0] <= f0;
            r_m[0] <= i_item.hdg;
        end
    end

    // stages 1..NS-1: CORDIC step if CI < CORDIC_STAGES; stage 1 sum, root digits
    for (genvar j = 1; j < NS; j++) begin : g_stage
        localparam int CI = j - 1;
        localparam int K  = NS - 1 - j;
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [ZW-1:0] nz;
        logic [SQ_W-1:0]      nn;
        logic [RW-1:0]        nres;

        if (CI < CORDIC_STAGES) begin : g_rot
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic                 ypos;
            always_comb begin
                xs   = r_x[j-1] >>> CI;
                ys   = r_y[j-1] >>> CI;
                ypos = !r_y[j-1][CW-1] && (r_y[j-1] != '0);
                if (ypos) begin
                    nx = r_x[j-1] + ys;
                    ny = r_y[j-1] - xs;
                    nz = r_z[j-1] + $signed(atan_lut(CI));
                end else begin
                    nx = r_x[j-1] - ys;
                    ny = r_y[j-1] + xs;
                    nz = r_z[j-1] - $signed(atan_lut(CI));
                end
            end
        end else begin : g_pass
            assign nx = r_x[j-1];
            assign ny = r_y[j-1];
            assign nz = r_z[j-1];
        end

        if (j == 1) begin : g_sum
            assign nn   = {1'b0, r_sqx} + {1'b0, r_sqy};
            assign nres = '0;
        end else begin : g_root
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);
            logic [RW-1:0] trial;
            always_comb begin
                trial = r_res[j-1] + BIT;
                if ({1'b0, r_n[j-1]} >= trial) begin
                    nn   = SQ_W'({1'b0, r_n[j-1]} - trial);
                    nres = (r_res[j-1] >> 1) + BIT;
                end else begin
                    nn   = r_n[j-1];
                    nres = r_res[j-1] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[j]   <= nx;
                r_y[j]   <= ny;
                r_z[j]   <= nz;
                r_f[j]   <= r_f[j-1];
                r_m[j]   <= r_m[j-1];
                r_n[j]   <= nn;
                r_res[j] <= nres;
            end
        end
    end

    // finish: round and wrap bearing, pick exact axis cases, apply speed rule
    logic signed [ZW-1:0]     zr;
    logic signed [ZW-9:0]     h;
    logic signed [ZW-9:0]     hw;
    logic [HDG_W-1:0]         bearing;
    logic [DW-1:0]            root_d;
    logic [CFG_W-1:0]         half;
    logic [CFG_W-1:0]         speed;
    t_flags                   fl;

    always_comb begin
        fl   = r_f[NS-1];
        zr   = r_z[NS-1] + ZW'(128);
        h    = zr[ZW-1:8];
        if (h < 0) begin
            hw = h + (ZW-8)'(FULL_TURN);
        end else if (h >= $signed((ZW-8)'(FULL_TURN))) begin
            hw = h - (ZW-8)'(FULL_TURN);
        end else begin
            hw = h;
        end
        priority if (fl.dx_zero) begin
            bearing = fl.dy_neg ? HALF_TURN : '0;
        end else if (fl.dy_zero) begin
            bearing = fl.dx_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
        end else begin
            bearing = hw[HDG_W-1:0];
        end
        root_d = r_res[NS-1][DW-1:0];
        half   = root_d[DW-1:1];
        if (!fl.far && (root_d < {1'b0, i_slow_zone})) begin
            speed = (half >= HALF_UNIT) ? half - HALF_UNIT : '0;
        end else begin
            speed = i_cruise_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fb   <= bearing;
            r_fspd <= speed;
            r_fm   <= r_m[NS-1];
            r_feq  <= fl.dx_zero && fl.dy_zero;
        end
    end

    // output register: heading error wrapped to half a turn either way
    logic signed [HDG_W:0] err;
    logic signed [HDG_W:0] errw;

    always_comb begin
        err = $signed({1'b0, r_fb}) - $signed({1'b0, r_fm});
        if (err > $signed({1'b0, HALF_TURN})) begin
            errw = err - $signed({1'b0, FULL_TURN});
        end else if (err < -$signed({1'b0, HALF_TURN})) begin
            errw = err + $signed({1'b0, FULL_TURN});
        end else begin
            errw = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ob   <= r_fb;
            r_ospd <= r_fspd;
            r_oerr <= errw[HDG_W-1:0];
            r_oeq  <= r_feq;
        end
    end

    assign o_valid         = r_ov;
    assign o_aimed_heading = r_ob;
    assign o_speed_cmd     = r_ospd;
    assign o_heading_error = r_oerr;
    assign o_points_equal  = r_oeq;

endmodule

// ===== sv/waypoint_bearing_speed_error_core.sv =====
// ----------------------------------------------------------------------------
// waypoint_bearing_speed_error_core: waypoint bearing, speed and heading error
// Compass bearing by CORDIC, distance by pipelined square root, speed setpoint
// and wrapped heading error, with a coincident-point flag.
//
//   channel   direction  fields (low bit up)
//   s         in         pos_x, pos_y, dest_x, dest_y, measured_heading
//   m         out        aimed_heading, speed_cmd, heading_error, points_equal
//   cfg       in         0 slow_zone, 1 cruise_speed
//
// One item per cycle sustained while the output is not stalled. From input
// accept to output accept an item passes the front register, the queue, the
// square and sum stages, 25 root stages, and the finish and output registers;
// the root pipeline sets the depth. Synchronous active-low reset empties all
// stages. A stall at the output holds the whole back pipeline; the queue and
// front register keep taking items until they fill.
// ----------------------------------------------------------------------------
module waypoint_bearing_speed_error_core import wbse_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // pos_x[23:0], pos_y[47:24], dest_x[71:48], dest_y[95:72], measured_heading[111:96]
    input  logic [111:0]       i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // aimed_heading[15:0], speed_cmd[39:16], heading_error[55:40], points_equal[56]
    output logic [63:0]        o_m_tdata,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [CFG_W-1:0] r_slow_zone;
    logic [CFG_W-1:0] r_cruise_speed;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_zone    <= 24'd2560;
            r_cruise_speed <= 24'd1280;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLOW_ZONE:    r_slow_zone    <= i_cfg_data;
                REG_CRUISE_SPEED: r_cruise_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic  f_valid;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_item f_item;
    t_item q_item;

    wbse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_pos_x  (i_s_tdata[23:0]),
        .i_pos_y  (i_s_tdata[47:24]),
        .i_dest_x (i_s_tdata[71:48]),
        .i_dest_y (i_s_tdata[95:72]),
        .i_hdg    (i_s_tdata[111:96]),
        .o_valid  (f_valid),
        .i_full   (q_full),
        .o_item   (f_item)
    );

    wbse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    logic [HDG_W-1:0] aimed_heading;
    logic [CFG_W-1:0] speed_cmd;
    logic [HDG_W-1:0] heading_error;
    logic             points_equal;

    wbse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .i_slow_zone     (r_slow_zone),
        .i_cruise_speed  (r_cruise_speed),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_aimed_heading (aimed_heading),
        .o_speed_cmd     (speed_cmd),
        .o_heading_error (heading_error),
        .o_points_equal  (points_equal)
    );

    assign o_m_tdata = {7'd0, points_equal, heading_error, speed_cmd, aimed_heading};

endmodule

// ===== sim/waypoint_bearing_speed_error_core_test.sv =====
// ----------------------------------------------------------------------------
// waypoint_bearing_speed_error_core_test: self-checking bench for the core
// Drives position/target/heading items over the input stream, predicts the
// bearing, speed setpoint, heading error and coincident flag of each item, and
// compares every output item in order. Runs several idle/stall phases and
// register settings, including the extremes.
// ----------------------------------------------------------------------------
module waypoint_bearing_speed_error_core_test;
    import wbse_pkg::*;

    typedef struct packed {
        logic        equal;
        logic [15:0] herr;
        logic [23:0] speed;
        logic [15:0] bearing;
    } t_guidance;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_idx = '0;
    logic [23:0]  i_cfg_data = '0;

    waypoint_bearing_speed_error_core dut (.*);

    // predictor copy of the registers
    logic [23:0] stop_dist_q = 24'd2560;
    logic [23:0] cruise_q    = 24'd1280;

    t_guidance   guidance_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycles = 0;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 60;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint cordic_heading(longint dx, longint dy);
        longint x, y, z, h, xs, ys, a;
        x = dy <<< CORDIC_GUARD;
        y = dx <<< CORDIC_GUARD;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(HALF_TURN) * 256;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            a = longint'(atan_lut(i));
            if (y > 0) begin
                x += ys; y -= xs; z += a;
            end else begin
                x -= ys; y += xs; z -= a;
            end
        end
        h = shr_floor(z + 128, 8);
        if (h < 0) h += 46080;
        if (h >= 46080) h -= 46080;
        return h;
    endfunction

    function automatic t_guidance predict_guidance(logic [111:0] d);
        t_guidance g;
        longint px, py, qx, qy, m, dx, dy, adx, ady, brg, err, sp, root_d;
        px = longint'($signed(d[23:0]));
        py = longint'($signed(d[47:24]));
        qx = longint'($signed(d[71:48]));
        qy = longint'($signed(d[95:72]));
        m  = longint'(d[111:96]) % 46080;
        dx = qx - px;
        dy = qy - py;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (dx == 0) brg = (dy >= 0) ? 0 : 23040;
        else if (dy == 0) brg = (dx > 0) ? 11520 : 34560;
        else brg = cordic_heading(dx, dy);
        sp = cruise_q;
        if (adx < (64'd1 << 24) && ady < (64'd1 << 24)) begin
            root_d = root_floor(adx * adx + ady * ady);
            if (root_d < longint'(stop_dist_q))
                sp = ((root_d >> 1) >= 128) ? (root_d >> 1) - 128 : 0;
        end
        err = brg - m;
        if (err > 23040) err -= 46080;
        else if (err < -23040) err += 46080;
        g.bearing = brg[15:0];
        g.speed   = sp[23:0];
        g.herr    = err[15:0];
        g.equal   = (dx == 0 && dy == 0);
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_guidance exp_g, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[56:0];
            if (guidance_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item %h", o_m_tdata);
            end else begin
                exp_g = guidance_q.pop_front();
                if (got !== exp_g || o_m_tdata[63:57] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hdg %0d spd %0d err %0d eq %0d / got %0d %0d %0d %0d",
                                 exp_g.bearing, exp_g.speed, $signed(exp_g.herr), exp_g.equal,
                                 got.bearing, got.speed, $signed(got.herr), got.equal);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // valid stays up after an accepted item until the next item or an idle
    // cycle replaces it in the same time step
    task automatic send_item(logic [23:0] px, logic [23:0] py, logic [23:0] qx,
                             logic [23:0] qy, logic [15:0] hdg);
        logic [111:0] d;
        d = {hdg, qy, qx, py, px};
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        guidance_q.push_back(predict_guidance(d));
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (guidance_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [23:0] val);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SLOW_ZONE) stop_dist_q = val;
        else cruise_q = val;
    endtask

    // small offsets most of the time so the ramp region is reached
    function automatic logic [23:0] near_offset(logic [23:0] base);
        case ($urandom_range(3))
            0: return base;
            1: return base + 24'($urandom_range(8191)) - 24'd4096;
            2: return base + 24'($urandom_range(511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random(int n);
        logic [23:0] px, py, qx, qy;
        for (int k = 0; k < n; k++) begin
            px = 24'($urandom);
            py = 24'($urandom);
            qx = near_offset(px);
            qy = near_offset(py);
            send_item(px, py, qx, qy,
                      ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(46079)));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_item(24'd100, 24'd200, 24'd100, 24'd200, 16'd0);       // coincident
        send_item(24'd0, 24'd0, 24'd0, 24'd500, 16'd46079);         // straight up
        send_item(24'd0, 24'd0, 24'd0, -24'd500, 16'd0);            // straight down
        send_item(24'd0, 24'd0, 24'd700, 24'd0, 16'd34560);         // east
        send_item(24'd0, 24'd0, -24'd700, 24'd0, 16'd11520);        // west, error at 180
        send_item(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'd100); // far
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF);
        send_item(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'd46080);
        send_item(24'd0, 24'd0, 24'd300, 24'd400, 16'd23040);
        send_item(24'd0, 24'd0, -24'd1, -24'd1, 16'd0);
        send_item(24'd0, 24'd0, 24'd1, -24'd1, 16'd23040);
        send_item(24'd10, 24'd10, 24'd266, 24'd10, 16'd0);          // d = 256, speed 0
        send_item(24'd0, 24'd0, 24'd2000, 24'd0, 16'd0);            // ramp
        send_item(24'd0, 24'd0, 24'd2560, 24'd0, 16'd0);            // at stop distance
        send_item(24'd0, 24'd0, 24'd2559, 24'd0, 16'd0);
        send_item(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd46079);
    endtask

    task automatic test_config_extremes();
        write_register(REG_SLOW_ZONE, 24'd0);
        write_register(REG_CRUISE_SPEED, 24'hFFFFFF);
        send_item(24'd5, 24'd5, 24'd5, 24'd5, 16'd0);               // coincident, top speed
        send_random(40);
        write_register(REG_SLOW_ZONE, 24'hFFFFFF);
        write_register(REG_CRUISE_SPEED, 24'd0);
        send_item(24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF, 16'd0);
        send_random(60);
        write_register(REG_SLOW_ZONE, 24'($urandom));
        write_register(REG_CRUISE_SPEED, 24'($urandom));
        send_random(40);
        write_register(REG_SLOW_ZONE, 24'd2560);
        write_register(REG_CRUISE_SPEED, 24'd1280);
    endtask

    task automatic test_phase(int idle, int stall, int n);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        send_random(n);
    endtask

    task automatic test_pause_until_drained();
        send_random(30);
        drain_results();
        send_random(30);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phase(0, 0, 300);
        test_config_extremes();
        test_phase(83, 0, 250);
        test_phase(0, 83, 250);
        test_pause_until_drained();
        test_phase(34, 34, 250);
        test_phase(0, 0, 50);
        drain_results();
        if (mismatches == 0 && guidance_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
